// ----- src/acr_pkg.sv -----
// Shared widths, types and stage records for the box pair collision pipeline.
package acr_pkg;

    // Field widths.
    localparam int POS_W  = 24;
    localparam int HALF_W = 16;
    // Box edges carry one extra bit so that center plus half size never wraps.
    localparam int EDGE_W = POS_W + 1;
    // On a hit an overlap is at most twice the smaller half size.
    localparam int OVL_W  = HALF_W + 1;

    typedef logic signed [POS_W-1:0]  pos_t;
    typedef logic        [HALF_W-1:0] half_t;
    typedef logic signed [EDGE_W-1:0] edge_t;
    typedef logic        [OVL_W-1:0]  ovl_t;

    // Body flags of the pair.
    typedef struct packed {
        logic a_trigger;
        logic b_trigger;
        logic b_static;
    } flags_t;

    // Centers of both boxes.
    typedef struct packed {
        pos_t a_x;
        pos_t a_y;
        pos_t b_x;
        pos_t b_y;
    } centers_t;

    // One request as it enters the pipeline.
    typedef struct packed {
        centers_t c;
        half_t    a_half_w;
        half_t    a_half_h;
        half_t    b_half_w;
        half_t    b_half_h;
        flags_t   f;
    } req_t;

    // After the edge stage.
    typedef struct packed {
        centers_t c;
        edge_t    a_min_x;
        edge_t    a_max_x;
        edge_t    a_min_y;
        edge_t    a_max_y;
        edge_t    b_min_x;
        edge_t    b_max_x;
        edge_t    b_min_y;
        edge_t    b_max_y;
        flags_t   f;
    } s1_t;

    // After the compare stage: overlap bounds and hit.
    typedef struct packed {
        centers_t c;
        logic     hit;
        logic     a_left;
        logic     a_below;
        edge_t    lo_x;
        edge_t    hi_x;
        edge_t    lo_y;
        edge_t    hi_y;
        flags_t   f;
    } s2_t;

    // After the overlap stage.
    typedef struct packed {
        centers_t c;
        logic     hit;
        logic     a_left;
        logic     a_below;
        ovl_t     ox;
        ovl_t     oy;
        flags_t   f;
    } s3_t;

    // After the decision stage: what to move and which flags to raise.
    typedef struct packed {
        centers_t c;
        logic     hit;
        logic     axis_x;
        logic     a_neg;
        ovl_t     move_a;
        ovl_t     move_b;
        logic     zero_a_vx;
        logic     zero_a_vy;
        logic     zero_b_vx;
        logic     zero_b_vy;
        logic     a_on_ground;
    } s4_t;

    // Final result record.
    typedef struct packed {
        logic hit;
        pos_t new_a_x;
        pos_t new_a_y;
        pos_t new_b_x;
        pos_t new_b_y;
        logic zero_a_vx;
        logic zero_a_vy;
        logic zero_b_vx;
        logic zero_b_vy;
        logic a_on_ground;
    } res_t;

endpackage

// ----- src/acr_edge.sv -----
// Edge stage: min and max edges of both boxes on both axes.
module acr_edge
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           valid_in,
    input  acr_pkg::req_t  req,
    output logic           valid_out,
    output acr_pkg::s1_t   s1
);

    logic         valid_reg;
    acr_pkg::s1_t s1_reg;
    acr_pkg::s1_t s1_next;

    // Sign extend the centers, zero extend the half sizes, then add and subtract.
    always_comb
    begin
        acr_pkg::edge_t ax;
        acr_pkg::edge_t ay;
        acr_pkg::edge_t bx;
        acr_pkg::edge_t by;
        ax = acr_pkg::edge_t'(req.c.a_x);
        ay = acr_pkg::edge_t'(req.c.a_y);
        bx = acr_pkg::edge_t'(req.c.b_x);
        by = acr_pkg::edge_t'(req.c.b_y);
        s1_next.c       = req.c;
        s1_next.f       = req.f;
        s1_next.a_min_x = ax - acr_pkg::edge_t'({1'b0, req.a_half_w});
        s1_next.a_max_x = ax + acr_pkg::edge_t'({1'b0, req.a_half_w});
        s1_next.a_min_y = ay - acr_pkg::edge_t'({1'b0, req.a_half_h});
        s1_next.a_max_y = ay + acr_pkg::edge_t'({1'b0, req.a_half_h});
        s1_next.b_min_x = bx - acr_pkg::edge_t'({1'b0, req.b_half_w});
        s1_next.b_max_x = bx + acr_pkg::edge_t'({1'b0, req.b_half_w});
        s1_next.b_min_y = by - acr_pkg::edge_t'({1'b0, req.b_half_h});
        s1_next.b_max_y = by + acr_pkg::edge_t'({1'b0, req.b_half_h});
    end

    // Valid bit is reset; payload is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
        end
    end

    assign valid_out = valid_reg;
    assign s1        = s1_reg;

endmodule

// ----- src/acr_overlap.sv -----
// Compare and overlap stages: hit test, overlap bounds, then overlap sizes.
module acr_overlap
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          valid_in,
    input  acr_pkg::s1_t  s1,
    output logic          valid_out,
    output acr_pkg::s3_t  s3
);

    logic         s2_valid_reg;
    acr_pkg::s2_t s2_reg;
    acr_pkg::s2_t s2_next;
    logic         s3_valid_reg;
    acr_pkg::s3_t s3_reg;
    acr_pkg::s3_t s3_next;

    // Strict overlap on both axes, and the inner bounds of the overlap.
    always_comb
    begin
        s2_next.c       = s1.c;
        s2_next.f       = s1.f;
        s2_next.hit     = ($signed(s1.a_min_x) < $signed(s1.b_max_x))
                       && ($signed(s1.a_max_x) > $signed(s1.b_min_x))
                       && ($signed(s1.a_min_y) < $signed(s1.b_max_y))
                       && ($signed(s1.a_max_y) > $signed(s1.b_min_y));
        s2_next.a_left  = $signed(s1.c.a_x) < $signed(s1.c.b_x);
        s2_next.a_below = $signed(s1.c.a_y) < $signed(s1.c.b_y);
        s2_next.lo_x    = ($signed(s1.a_min_x) > $signed(s1.b_min_x)) ? s1.a_min_x
                                                                       : s1.b_min_x;
        s2_next.hi_x    = ($signed(s1.a_max_x) < $signed(s1.b_max_x)) ? s1.a_max_x
                                                                       : s1.b_max_x;
        s2_next.lo_y    = ($signed(s1.a_min_y) > $signed(s1.b_min_y)) ? s1.a_min_y
                                                                       : s1.b_min_y;
        s2_next.hi_y    = ($signed(s1.a_max_y) < $signed(s1.b_max_y)) ? s1.a_max_y
                                                                       : s1.b_max_y;
    end

    // Overlap sizes. They only matter on a hit, where they fit OVL_W bits.
    always_comb
    begin
        acr_pkg::edge_t dx;
        acr_pkg::edge_t dy;
        dx = s2_reg.hi_x - s2_reg.lo_x;
        dy = s2_reg.hi_y - s2_reg.lo_y;
        s3_next.c       = s2_reg.c;
        s3_next.f       = s2_reg.f;
        s3_next.hit     = s2_reg.hit;
        s3_next.a_left  = s2_reg.a_left;
        s3_next.a_below = s2_reg.a_below;
        s3_next.ox      = dx[acr_pkg::OVL_W-1:0];
        s3_next.oy      = dy[acr_pkg::OVL_W-1:0];
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= valid_in;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

    assign valid_out = s3_valid_reg;
    assign s3        = s3_reg;

endmodule

// ----- src/acr_resolve.sv -----
// Decision and update stages: pick the axis, size the pushes, move the centers.
module acr_resolve
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          valid_in,
    input  acr_pkg::s3_t  s3,
    output logic          valid_out,
    output acr_pkg::res_t res
);

    logic          s4_valid_reg;
    acr_pkg::s4_t  s4_reg;
    acr_pkg::s4_t  s4_next;
    logic          res_valid_reg;
    acr_pkg::res_t res_reg;
    acr_pkg::res_t res_next;

    // Axis choice (a tie resolves vertically), push sizes and velocity flags.
    always_comb
    begin
        logic solid;
        logic horiz;
        solid = !s3.f.a_trigger && !s3.f.b_trigger;
        horiz = s3.ox < s3.oy;

        s4_next.c           = s3.c;
        s4_next.hit         = s3.hit;
        s4_next.axis_x      = horiz;
        s4_next.a_neg       = horiz ? s3.a_left : s3.a_below;
        s4_next.move_a      = '0;
        s4_next.move_b      = '0;
        s4_next.zero_a_vx   = 1'b0;
        s4_next.zero_a_vy   = 1'b0;
        s4_next.zero_b_vx   = 1'b0;
        s4_next.zero_b_vy   = 1'b0;
        s4_next.a_on_ground = 1'b0;

        if (s3.hit)
        begin
            if (horiz)
            begin
                if (solid)
                begin
                    s4_next.move_a = s3.f.b_static ? s3.ox : (s3.ox >> 1);
                    s4_next.move_b = s3.f.b_static ? '0 : (s3.ox >> 1);
                end
                s4_next.zero_a_vx = !s3.f.a_trigger;
                s4_next.zero_b_vx = !s3.f.b_static && !s3.f.b_trigger;
            end
            else if (solid)
            begin
                s4_next.move_a      = s3.f.b_static ? s3.oy : (s3.oy >> 1);
                s4_next.move_b      = s3.f.b_static ? '0 : (s3.oy >> 1);
                s4_next.zero_a_vy   = 1'b1;
                s4_next.zero_b_vy   = !s3.f.b_static;
                s4_next.a_on_ground = !s3.a_below;
            end
        end
    end

    // Apply the pushes; B's push, where nonzero, goes opposite to A's, modulo 2^24.
    always_comb
    begin
        acr_pkg::pos_t da;
        acr_pkg::pos_t db;
        da = acr_pkg::pos_t'({1'b0, s4_reg.move_a});
        db = acr_pkg::pos_t'({1'b0, s4_reg.move_b});

        res_next.hit         = s4_reg.hit;
        res_next.zero_a_vx   = s4_reg.zero_a_vx;
        res_next.zero_a_vy   = s4_reg.zero_a_vy;
        res_next.zero_b_vx   = s4_reg.zero_b_vx;
        res_next.zero_b_vy   = s4_reg.zero_b_vy;
        res_next.a_on_ground = s4_reg.a_on_ground;
        res_next.new_a_x     = s4_reg.c.a_x;
        res_next.new_a_y     = s4_reg.c.a_y;
        res_next.new_b_x     = s4_reg.c.b_x;
        res_next.new_b_y     = s4_reg.c.b_y;

        if (s4_reg.axis_x)
        begin
            res_next.new_a_x = s4_reg.a_neg ? s4_reg.c.a_x - da : s4_reg.c.a_x + da;
            res_next.new_b_x = s4_reg.a_neg ? s4_reg.c.b_x + db : s4_reg.c.b_x - db;
        end
        else
        begin
            res_next.new_a_y = s4_reg.a_neg ? s4_reg.c.a_y - da : s4_reg.c.a_y + da;
            res_next.new_b_y = s4_reg.a_neg ? s4_reg.c.b_y + db : s4_reg.c.b_y - db;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg  <= valid_in;
            res_valid_reg <= s4_valid_reg;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_reg  <= s4_next;
            res_reg <= res_next;
        end
    end

    assign valid_out = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- src/aabb_pair_collision_resolve.sv -----
// Top level of the box pair collision resolver: ports, pipeline enable, checks.
//
// Each request carries one pair of axis-aligned boxes and returns one result.
// The pipeline has five register stages (edges, bounds and hit, overlap,
// axis decision, position update), and a new request can be accepted in every
// cycle in which in_stall is low.
// The whole pipeline advances together: in_stall is raised only while a
// finished result sits at the output and out_stall holds it there.
module aabb_pair_collision_resolve
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [acr_pkg::POS_W-1:0]  a_x,
    input  logic signed [acr_pkg::POS_W-1:0]  a_y,
    input  logic        [acr_pkg::HALF_W-1:0] a_half_w,
    input  logic        [acr_pkg::HALF_W-1:0] a_half_h,
    input  logic signed [acr_pkg::POS_W-1:0]  b_x,
    input  logic signed [acr_pkg::POS_W-1:0]  b_y,
    input  logic        [acr_pkg::HALF_W-1:0] b_half_w,
    input  logic        [acr_pkg::HALF_W-1:0] b_half_h,
    input  logic                       a_trigger,
    input  logic                       b_trigger,
    input  logic                       b_static,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       hit,
    output logic signed [acr_pkg::POS_W-1:0]  new_a_x,
    output logic signed [acr_pkg::POS_W-1:0]  new_a_y,
    output logic signed [acr_pkg::POS_W-1:0]  new_b_x,
    output logic signed [acr_pkg::POS_W-1:0]  new_b_y,
    output logic                       zero_a_vx,
    output logic                       zero_a_vy,
    output logic                       zero_b_vx,
    output logic                       zero_b_vy,
    output logic                       a_on_ground
);

    acr_pkg::req_t req;
    acr_pkg::s1_t  s1;
    acr_pkg::s3_t  s3;
    acr_pkg::res_t res;
    logic          s1_valid;
    logic          s3_valid;
    logic          res_valid;
    logic          en;

    // The pipeline moves unless a held result blocks the output.
    assign en       = !(res_valid && out_stall);
    assign in_stall = !en;

    // Pack the request.
    always_comb
    begin
        req.c.a_x      = a_x;
        req.c.a_y      = a_y;
        req.c.b_x      = b_x;
        req.c.b_y      = b_y;
        req.a_half_w   = a_half_w;
        req.a_half_h   = a_half_h;
        req.b_half_w   = b_half_w;
        req.b_half_h   = b_half_h;
        req.f.a_trigger = a_trigger;
        req.f.b_trigger = b_trigger;
        req.f.b_static  = b_static;
    end

    acr_edge u_edge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (in_valid),
        .req       (req),
        .valid_out (s1_valid),
        .s1        (s1)
    );

    acr_overlap u_overlap
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (s1_valid),
        .s1        (s1),
        .valid_out (s3_valid),
        .s3        (s3)
    );

    acr_resolve u_resolve
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (s3_valid),
        .s3        (s3),
        .valid_out (res_valid),
        .res       (res)
    );

    // Unpack the result.
    assign out_valid   = res_valid;
    assign hit         = res.hit;
    assign new_a_x     = res.new_a_x;
    assign new_a_y     = res.new_a_y;
    assign new_b_x     = res.new_b_x;
    assign new_b_y     = res.new_b_y;
    assign zero_a_vx   = res.zero_a_vx;
    assign zero_a_vy   = res.zero_a_vy;
    assign zero_b_vx   = res.zero_b_vx;
    assign zero_b_vy   = res.zero_b_vy;
    assign a_on_ground = res.a_on_ground;

    // The input is held back only by a stalled, valid result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a blocked result");

    // A result resolves along one axis only.
    a_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !((zero_a_vx || zero_b_vx) && (zero_a_vy || zero_b_vy)))
        else $error("velocity cleared on both axes");

    // Landing implies a vertical resolution that clears A's vertical velocity.
    a_ground_vy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && a_on_ground) |-> (hit && zero_a_vy))
        else $error("landing reported without vertical resolution");

    // Without a hit no flag is raised.
    a_miss_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> !(zero_a_vx || zero_a_vy || zero_b_vx || zero_b_vy
                                  || a_on_ground))
        else $error("flags raised without a hit");

endmodule
